/* rtl/imu_complementary_tilt_filter_assert.svh */
// assertion macros for the tilt filter checks
`ifndef IMU_COMPLEMENTARY_TILT_FILTER_ASSERT_SVH
`define IMU_COMPLEMENTARY_TILT_FILTER_ASSERT_SVH

// same-cycle implication, disabled in reset
`define ICTF_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, disabled in reset
`define ICTF_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/ictf_pkg.sv */
// shared types, constants and the arctangent table of the tilt filter
`timescale 1ns / 1ps

package ictf_pkg;

  // field and datapath widths
  localparam int ANGLE_W  = 16;
  localparam int CORDIC_W = 27;
  localparam int FINE_W   = 25;
  localparam int STEP_W   = 5;
  localparam int TABLE_LEN = 24;

  // angle range in 1/128 degree
  localparam logic signed [ANGLE_W-1:0] ANGLE_LIMIT = 16'sd23040;
  localparam logic signed [16:0] CONV_LIMIT = 17'sd23040;

  // half turn in 1/32768 degree
  localparam logic signed [FINE_W-1:0] HALF_TURN_FINE = 25'sd5898240;
  localparam logic signed [FINE_W-1:0] CONV_HALF = 25'sd128;

  // blend weight reset value, 0.955 in q0.16
  localparam logic [15:0] WEIGHT_RESET = 16'd62587;
  localparam logic [16:0] WEIGHT_ONE = 17'h10000;

  // blend scaling: divide by 32768000 as a shift by 15 and a divide by 1000
  localparam logic signed [27:0] DEG_SCALE  = 28'sd500;
  localparam logic signed [45:0] ROUND_HALF = 46'sd16384000;
  localparam logic signed [30:0] SAT_HI_LIM = 31'sd23041000;
  localparam logic signed [30:0] SAT_LO_LIM = -31'sd23040000;
  localparam logic signed [30:0] QUOT_BIAS  = 31'sd23040000;
  localparam logic signed [17:0] QUOT_OFFSET = 18'sd23040;
  // ceil(2^36 / 1000), exact for dividends below 2^26
  localparam logic signed [27:0] RECIP_1000 = 28'sd68719477;

  // axis index of the last axis
  localparam logic [1:0] LAST_AXIS = 2'd2;

  // main sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_CSTART,
    ST_CWAIT,
    ST_GYRO,
    ST_OLD,
    ST_GAIN,
    ST_ACCEL,
    ST_MIX,
    ST_ROUND,
    ST_SCALE,
    ST_OUT
  } ictf_state_t;

  // cordic engine states
  typedef enum logic [1:0] {
    CS_IDLE,
    CS_ITER,
    CS_CONV
  } cordic_state_t;

  // cordic result toward the sequencer
  typedef struct packed {
    logic                      done;
    logic signed [ANGLE_W-1:0] angle;
  } cordic_res_t;

  // round(atan(2^-i) degrees * 32768)
  function automatic logic signed [FINE_W-1:0] atan_fine(input logic [STEP_W-1:0] idx);
    logic signed [FINE_W-1:0] v;
    case (idx)
      5'd0:    v = 25'sd1474560;
      5'd1:    v = 25'sd870484;
      5'd2:    v = 25'sd459940;
      5'd3:    v = 25'sd233473;
      5'd4:    v = 25'sd117189;
      5'd5:    v = 25'sd58652;
      5'd6:    v = 25'sd29333;
      5'd7:    v = 25'sd14667;
      5'd8:    v = 25'sd7334;
      5'd9:    v = 25'sd3667;
      5'd10:   v = 25'sd1833;
      5'd11:   v = 25'sd917;
      5'd12:   v = 25'sd458;
      5'd13:   v = 25'sd229;
      5'd14:   v = 25'sd115;
      5'd15:   v = 25'sd57;
      5'd16:   v = 25'sd29;
      5'd17:   v = 25'sd14;
      5'd18:   v = 25'sd7;
      5'd19:   v = 25'sd4;
      5'd20:   v = 25'sd2;
      5'd21:   v = 25'sd1;
      default: v = 25'sd0;
    endcase
    return v;
  endfunction

endpackage

/* rtl/ictf_in_if.sv */
// sample channel: accelerometer, gyro rates and elapsed time
`timescale 1ns / 1ps

interface ictf_in_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] accel_x;
  logic signed [15:0] accel_y;
  logic signed [15:0] accel_z;
  logic signed [15:0] rate_x;
  logic signed [15:0] rate_y;
  logic signed [15:0] rate_z;
  logic [11:0]        elapsed_ms;

  modport source (
    output valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, elapsed_ms,
    input  ready
  );
  modport sink (
    input  valid, accel_x, accel_y, accel_z, rate_x, rate_y, rate_z, elapsed_ms,
    output ready
  );
endinterface

/* rtl/ictf_out_if.sv */
// attitude channel: filtered roll, pitch and yaw
`timescale 1ns / 1ps

interface ictf_out_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] roll_angle;
  logic signed [15:0] pitch_angle;
  logic signed [15:0] yaw_angle;

  modport source (
    output valid, roll_angle, pitch_angle, yaw_angle,
    input  ready
  );
  modport sink (
    input  valid, roll_angle, pitch_angle, yaw_angle,
    output ready
  );
endinterface

/* rtl/imu_complementary_tilt_filter.sv */
// three-axis complementary tilt filter with a shared cordic and a shared multiplier
// the single cordic engine runs three times in turn, once per axis, then seven blend
// steps run per axis; the result then loads once no previous attitude is still pending,
// and a new sample is accepted only after that load
// reset: angles clear to zero, blend weight returns to 62587, the first sample uses zero time
`timescale 1ns / 1ps
`include "imu_complementary_tilt_filter_assert.svh"

module imu_complementary_tilt_filter #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        weight_we,
  input  logic [15:0] weight_data,
  ictf_in_if.sink     sample,
  ictf_out_if.source  attitude
);

  ictf_pkg::ictf_state_t state, state_next;

  logic [1:0]         axis;
  logic               first_pending;
  logic [15:0]        weight;

  // captured sample
  logic signed [15:0] accel_x_q, accel_y_q, accel_z_q;
  logic signed [15:0] rate_q [3];
  logic [11:0]        ms_q;

  // per-axis angles
  logic signed [15:0] accel_ang [3];
  logic signed [15:0] angle_store [3];

  // blend datapath
  logic signed [29:0] pre;
  logic signed [45:0] macc;
  logic [25:0]        xo;
  logic               sat_hi, sat_lo;

  // output register
  logic               out_valid;
  logic signed [15:0] out_roll, out_pitch, out_yaw;
  logic               out_load;
  logic               out_in_range;

  // shared multiplier
  logic signed [29:0] mul_a;
  logic signed [27:0] mul_b;
  logic signed [57:0] mul_p;
  logic [16:0]        accel_gain;

  logic signed [45:0] rnd;
  logic signed [30:0] blend_q;
  logic signed [30:0] blend_bias;
  logic [16:0]        quot;
  logic signed [17:0] quot_adj;
  logic signed [15:0] blend_res;

  // cordic engine
  logic                  cordic_start;
  logic signed [15:0]    cordic_q, cordic_p;
  ictf_pkg::cordic_res_t cordic_res;

  ictf_cordic #(
    .STEPS (CORDIC_STEPS)
  ) u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cordic_start),
    .vec_q (cordic_q),
    .vec_p (cordic_p),
    .res   (cordic_res)
  );

  // cordic operand select per axis
  always_comb begin
    case (axis)
      2'd0: begin
        cordic_q = accel_y_q;
        cordic_p = accel_z_q;
      end
      2'd1: begin
        cordic_q = accel_x_q;
        cordic_p = accel_z_q;
      end
      default: begin
        cordic_q = accel_x_q;
        cordic_p = accel_y_q;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ictf_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // sequencer next state and strobes
  always_comb begin
    state_next   = state;
    sample.ready = 1'b0;
    cordic_start = 1'b0;
    out_load     = 1'b0;
    case (state)
      ictf_pkg::ST_IDLE: begin
        sample.ready = 1'b1;
        if (sample.valid) state_next = ictf_pkg::ST_CSTART;
      end
      ictf_pkg::ST_CSTART: begin
        cordic_start = 1'b1;
        state_next   = ictf_pkg::ST_CWAIT;
      end
      ictf_pkg::ST_CWAIT: begin
        if (cordic_res.done) begin
          state_next = (axis == ictf_pkg::LAST_AXIS) ? ictf_pkg::ST_GYRO : ictf_pkg::ST_CSTART;
        end
      end
      ictf_pkg::ST_GYRO:  state_next = ictf_pkg::ST_OLD;
      ictf_pkg::ST_OLD:   state_next = ictf_pkg::ST_GAIN;
      ictf_pkg::ST_GAIN:  state_next = ictf_pkg::ST_ACCEL;
      ictf_pkg::ST_ACCEL: state_next = ictf_pkg::ST_MIX;
      ictf_pkg::ST_MIX:   state_next = ictf_pkg::ST_ROUND;
      ictf_pkg::ST_ROUND: state_next = ictf_pkg::ST_SCALE;
      ictf_pkg::ST_SCALE: begin
        state_next = (axis == ictf_pkg::LAST_AXIS) ? ictf_pkg::ST_OUT : ictf_pkg::ST_GYRO;
      end
      ictf_pkg::ST_OUT: begin
        if (!out_valid || attitude.ready) begin
          out_load   = 1'b1;
          state_next = ictf_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = ictf_pkg::ST_IDLE;
      end
    endcase
  end

  // multiplier operand select
  assign accel_gain = ictf_pkg::WEIGHT_ONE - {1'b0, weight};

  always_comb begin
    case (state)
      ictf_pkg::ST_GYRO: begin
        mul_a = 30'(rate_q[axis]);
        mul_b = {16'b0, ms_q};
      end
      ictf_pkg::ST_OLD: begin
        mul_a = 30'(angle_store[axis]);
        mul_b = ictf_pkg::DEG_SCALE;
      end
      ictf_pkg::ST_GAIN: begin
        mul_a = pre;
        mul_b = {12'b0, weight};
      end
      ictf_pkg::ST_ACCEL: begin
        mul_a = 30'(accel_ang[axis]);
        mul_b = ictf_pkg::DEG_SCALE;
      end
      ictf_pkg::ST_MIX: begin
        mul_a = pre;
        mul_b = {11'b0, accel_gain};
      end
      ictf_pkg::ST_SCALE: begin
        mul_a = {4'b0, xo};
        mul_b = ictf_pkg::RECIP_1000;
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  assign mul_p = mul_a * mul_b;

  // round-half-up, shift by 15, bias into the unsigned divide range
  assign rnd        = macc + ictf_pkg::ROUND_HALF;
  assign blend_q    = rnd[45:15];
  assign blend_bias = blend_q + ictf_pkg::QUOT_BIAS;

  // divide by 1000 through the reciprocal, then remove the bias and saturate
  assign quot     = mul_p[52:36];
  assign quot_adj = $signed({1'b0, quot}) - ictf_pkg::QUOT_OFFSET;

  always_comb begin
    if (sat_hi) begin
      blend_res = ictf_pkg::ANGLE_LIMIT;
    end else if (sat_lo) begin
      blend_res = -ictf_pkg::ANGLE_LIMIT;
    end else begin
      blend_res = quot_adj[15:0];
    end
  end

  // control state: axis counter, first sample flag, weight register
  always_ff @(posedge clk) begin
    if (rst) begin
      axis          <= '0;
      first_pending <= 1'b1;
      weight        <= ictf_pkg::WEIGHT_RESET;
    end else begin
      if (weight_we) weight <= weight_data;
      if (sample.valid && sample.ready) first_pending <= 1'b0;
      if ((state == ictf_pkg::ST_CWAIT && cordic_res.done) || state == ictf_pkg::ST_SCALE) begin
        axis <= (axis == ictf_pkg::LAST_AXIS) ? 2'd0 : axis + 2'd1;
      end
    end
  end

  // filtered angle store
  always_ff @(posedge clk) begin
    if (rst) begin
      angle_store[0] <= '0;
      angle_store[1] <= '0;
      angle_store[2] <= '0;
    end else if (state == ictf_pkg::ST_SCALE) begin
      angle_store[axis] <= blend_res;
    end
  end

  // sample capture, zero elapsed time on the first sample
  always_ff @(posedge clk) begin
    if (sample.valid && sample.ready) begin
      accel_x_q <= sample.accel_x;
      accel_y_q <= sample.accel_y;
      accel_z_q <= sample.accel_z;
      rate_q[0] <= sample.rate_x;
      rate_q[1] <= sample.rate_y;
      rate_q[2] <= sample.rate_z;
      ms_q      <= first_pending ? 12'd0 : sample.elapsed_ms;
    end
  end

  // accelerometer angle capture
  always_ff @(posedge clk) begin
    if (state == ictf_pkg::ST_CWAIT && cordic_res.done) begin
      accel_ang[axis] <= cordic_res.angle;
    end
  end

  // blend accumulation steps
  always_ff @(posedge clk) begin
    case (state)
      ictf_pkg::ST_GYRO:  pre  <= mul_p[29:0];
      ictf_pkg::ST_OLD:   pre  <= pre + mul_p[29:0];
      ictf_pkg::ST_GAIN:  macc <= mul_p[45:0];
      ictf_pkg::ST_ACCEL: pre  <= mul_p[29:0];
      ictf_pkg::ST_MIX:   macc <= macc + mul_p[45:0];
      ictf_pkg::ST_ROUND: begin
        sat_hi <= (blend_q >= ictf_pkg::SAT_HI_LIM);
        sat_lo <= (blend_q < ictf_pkg::SAT_LO_LIM);
        xo     <= blend_bias[25:0];
      end
      default: begin
      end
    endcase
  end

  // output register, holds until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (attitude.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_roll  <= angle_store[0];
      out_pitch <= angle_store[1];
      out_yaw   <= angle_store[2];
    end
  end

  assign attitude.valid       = out_valid;
  assign attitude.roll_angle  = out_roll;
  assign attitude.pitch_angle = out_pitch;
  assign attitude.yaw_angle   = out_yaw;

  // range check of the presented result
  assign out_in_range = (out_roll  <= ictf_pkg::ANGLE_LIMIT) && (out_roll  >= -ictf_pkg::ANGLE_LIMIT)
                     && (out_pitch <= ictf_pkg::ANGLE_LIMIT) && (out_pitch >= -ictf_pkg::ANGLE_LIMIT)
                     && (out_yaw   <= ictf_pkg::ANGLE_LIMIT) && (out_yaw   >= -ictf_pkg::ANGLE_LIMIT);

  // checks
  `ICTF_ASSERT_NOW(a_out_range, clk, rst, out_valid, out_in_range, "attitude out of range")
  `ICTF_ASSERT_NEXT(a_busy_after_req, clk, rst, sample.valid && sample.ready, !sample.ready, "ready after request")
  `ICTF_ASSERT_NEXT(a_first_cleared, clk, rst, sample.valid && sample.ready, !first_pending, "first flag kept")
  `ICTF_ASSERT_NOW(a_cordic_done_wait, clk, rst, cordic_res.done, state == ictf_pkg::ST_CWAIT, "stray cordic done")

endmodule

/* rtl/ictf_cordic.sv */
// vectoring cordic engine: atan2(q, p) in 1/128 degree, one rotation per cycle
`timescale 1ns / 1ps

module ictf_cordic #(
  parameter int STEPS = 16
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [15:0]        vec_q,
  input  logic signed [15:0]        vec_p,
  output ictf_pkg::cordic_res_t     res
);

  localparam int NUM_STEPS = (STEPS > ictf_pkg::TABLE_LEN) ? ictf_pkg::TABLE_LEN : STEPS;
  localparam logic [ictf_pkg::STEP_W-1:0] LAST_STEP = ictf_pkg::STEP_W'(NUM_STEPS - 1);

  ictf_pkg::cordic_state_t state, state_next;

  logic [ictf_pkg::STEP_W-1:0]          step;
  logic signed [ictf_pkg::CORDIC_W-1:0] p, q;
  logic signed [ictf_pkg::FINE_W-1:0]   acc;
  logic                                 zero;
  logic                                 res_done;
  logic signed [ictf_pkg::ANGLE_W-1:0]  res_angle;

  logic signed [ictf_pkg::CORDIC_W-1:0] p_ext, q_ext, ps, qs;
  logic signed [ictf_pkg::FINE_W-1:0]   step_angle;
  logic signed [ictf_pkg::FINE_W-1:0]   conv_sum;
  logic signed [16:0]                   conv_q;

  // scale by 256 and sign extend
  assign p_ext = {{3{vec_p[15]}}, vec_p, 8'b0};
  assign q_ext = {{3{vec_q[15]}}, vec_q, 8'b0};

  // shared shifter and table lookup
  assign ps         = p >>> step;
  assign qs         = q >>> step;
  assign step_angle = ictf_pkg::atan_fine(step);

  // round to 1/128 degree
  assign conv_sum = acc + ictf_pkg::CONV_HALF;
  assign conv_q   = conv_sum[ictf_pkg::FINE_W-1:8];

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ictf_pkg::CS_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ictf_pkg::CS_IDLE: begin
        if (start) state_next = ictf_pkg::CS_ITER;
      end
      ictf_pkg::CS_ITER: begin
        if (step == LAST_STEP) state_next = ictf_pkg::CS_CONV;
      end
      ictf_pkg::CS_CONV: begin
        state_next = ictf_pkg::CS_IDLE;
      end
      default: begin
        state_next = ictf_pkg::CS_IDLE;
      end
    endcase
  end

  // step counter and done flag
  always_ff @(posedge clk) begin
    if (rst) begin
      step     <= '0;
      res_done <= 1'b0;
    end else begin
      res_done <= (state == ictf_pkg::CS_CONV);
      if (state == ictf_pkg::CS_IDLE) begin
        step <= '0;
      end else if (state == ictf_pkg::CS_ITER) begin
        step <= step + 1'b1;
      end
    end
  end

  // vector rotation and angle accumulation
  always_ff @(posedge clk) begin
    case (state)
      ictf_pkg::CS_IDLE: begin
        if (start) begin
          zero <= (vec_p == 16'sd0) && (vec_q == 16'sd0);
          if (vec_p[15]) begin
            p   <= -p_ext;
            q   <= -q_ext;
            acc <= vec_q[15] ? -ictf_pkg::HALF_TURN_FINE : ictf_pkg::HALF_TURN_FINE;
          end else begin
            p   <= p_ext;
            q   <= q_ext;
            acc <= '0;
          end
        end
      end
      ictf_pkg::CS_ITER: begin
        if (!q[ictf_pkg::CORDIC_W-1]) begin
          p   <= p + qs;
          q   <= q - ps;
          acc <= acc + step_angle;
        end else begin
          p   <= p - qs;
          q   <= q + ps;
          acc <= acc - step_angle;
        end
      end
      ictf_pkg::CS_CONV: begin
        if (zero) begin
          res_angle <= '0;
        end else if (conv_q > ictf_pkg::CONV_LIMIT) begin
          res_angle <= ictf_pkg::ANGLE_LIMIT;
        end else if (conv_q < -ictf_pkg::CONV_LIMIT) begin
          res_angle <= -ictf_pkg::ANGLE_LIMIT;
        end else begin
          res_angle <= conv_q[ictf_pkg::ANGLE_W-1:0];
        end
      end
      default: begin
      end
    endcase
  end

  assign res.done  = res_done;
  assign res.angle = res_angle;

endmodule
